FILE: sv/assert_macros.svh
// Assertion macros used by source_text_tokenizer.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define STT_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("stt assertion failed");

// Checks that a consequent holds in the same cycle as its antecedent.
`define STT_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("stt assertion failed");

`endif

FILE: sv/stt_pkg.sv
package stt_pkg;

  localparam int TEXT_W            = 8;
  localparam int KIND_W            = 5;
  localparam int OFFSET_W          = 24;
  localparam int LINE_W            = 16;
  localparam int POSITION_BITS_DEF = 24;
  localparam int LINE_BITS_DEF     = 16;

  localparam int RES_DEPTH = 4;
  localparam int RES_PTR_W = $clog2(RES_DEPTH);
  localparam int RES_CNT_W = RES_PTR_W + 1;

  localparam logic [TEXT_W-1:0] CH_NUL    = 8'h00;
  localparam logic [TEXT_W-1:0] CH_BS     = 8'h08;
  localparam logic [TEXT_W-1:0] CH_TAB    = 8'h09;
  localparam logic [TEXT_W-1:0] CH_LF     = 8'h0A;
  localparam logic [TEXT_W-1:0] CH_VT     = 8'h0B;
  localparam logic [TEXT_W-1:0] CH_CR     = 8'h0D;
  localparam logic [TEXT_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [TEXT_W-1:0] CH_QUOTE  = 8'h27;
  localparam logic [TEXT_W-1:0] CH_DOT    = 8'h2E;
  localparam logic [TEXT_W-1:0] CH_COLON  = 8'h3A;
  localparam logic [TEXT_W-1:0] CH_LT     = 8'h3C;
  localparam logic [TEXT_W-1:0] CH_EQUAL  = 8'h3D;
  localparam logic [TEXT_W-1:0] CH_GT     = 8'h3E;
  localparam logic [TEXT_W-1:0] CH_UNDER  = 8'h5F;
  localparam logic [TEXT_W-1:0] CH_LBRACE = 8'h7B;
  localparam logic [TEXT_W-1:0] CH_RBRACE = 8'h7D;

  typedef enum logic [KIND_W-1:0] {
    KIND_COMMENT = 5'd0,
    KIND_LPAREN  = 5'd1,
    KIND_RPAREN  = 5'd2,
    KIND_SEMI    = 5'd3,
    KIND_PLUS    = 5'd4,
    KIND_MINUS   = 5'd5,
    KIND_STAR    = 5'd6,
    KIND_SLASH   = 5'd7,
    KIND_CARET   = 5'd8,
    KIND_EQUAL   = 5'd9,
    KIND_HASH    = 5'd10,
    KIND_AMP     = 5'd11,
    KIND_BAR     = 5'd12,
    KIND_PERCENT = 5'd13,
    KIND_STRING  = 5'd14,
    KIND_LT      = 5'd15,
    KIND_LE      = 5'd16,
    KIND_GT      = 5'd17,
    KIND_GE      = 5'd18,
    KIND_ASSIGN  = 5'd19,
    KIND_NUMBER  = 5'd20,
    KIND_IDENT   = 5'd21,
    KIND_INVALID = 5'd22,
    KIND_END     = 5'd23,
    KIND_ABORT   = 5'd24
  } token_kind_e;

  typedef struct packed {
    token_kind_e         kind;
    logic [OFFSET_W-1:0] start_off;
    logic [OFFSET_W-1:0] end_off;
    logic [LINE_W-1:0]   line;
    logic                clean;
    logic                last;
  } tok_rec_t;

  typedef struct packed {
    logic [1:0] count;
    tok_rec_t   rec0;
    tok_rec_t   rec1;
  } scan_out_t;

  function automatic logic is_end(input logic [TEXT_W-1:0] b);
    return (b == CH_NUL) || (b == CH_BS) || (b == CH_VT);
  endfunction

  function automatic logic is_digit(input logic [TEXT_W-1:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_letter(input logic [TEXT_W-1:0] b);
    return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
  endfunction

  function automatic token_kind_e op_kind(input logic [TEXT_W-1:0] b);
    token_kind_e k;
    case (b)
      8'h28:   k = KIND_LPAREN;
      8'h29:   k = KIND_RPAREN;
      8'h3B:   k = KIND_SEMI;
      8'h2B:   k = KIND_PLUS;
      8'h2D:   k = KIND_MINUS;
      8'h2A:   k = KIND_STAR;
      8'h2F:   k = KIND_SLASH;
      8'h5E:   k = KIND_CARET;
      8'h3D:   k = KIND_EQUAL;
      8'h23:   k = KIND_HASH;
      8'h26:   k = KIND_AMP;
      8'h7C:   k = KIND_BAR;
      8'h25:   k = KIND_PERCENT;
      default: k = KIND_INVALID;
    endcase
    return k;
  endfunction

endpackage

FILE: sv/stt_scan.sv
module stt_scan import stt_pkg::*; #(
  parameter int POSITION_BITS = POSITION_BITS_DEF,
  parameter int LINE_BITS     = LINE_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  logic [TEXT_W-1:0] byte_i,
  output scan_out_t         scan_o
);

  typedef enum logic [3:0] {
    MODE_IDLE,
    MODE_IDENT,
    MODE_NUM,
    MODE_NUM_DOT,
    MODE_LT,
    MODE_GT,
    MODE_COLON,
    MODE_COMMENT,
    MODE_STRING,
    MODE_HALT
  } scan_mode_e;

  localparam logic [POSITION_BITS-1:0] POS_MAX  = '1;
  localparam logic [LINE_BITS-1:0]     LINE_MAX = '1;
  localparam logic [LINE_BITS-1:0]     LINE_ONE = LINE_BITS'(1);

  scan_mode_e               mode_q, mode_d;
  logic [POSITION_BITS-1:0] begin_q, begin_d;
  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic [LINE_BITS-1:0]     line_q, line_d;
  logic                     inval_q, inval_d;

  logic [POSITION_BITS-1:0] nxt;
  logic                     first_v, idle_v, rescan, restart;
  token_kind_e              first_k, idle_k;
  logic [POSITION_BITS-1:0] first_s, first_e, idle_s, idle_e;
  logic                     idle_clean;
  tok_rec_t                 first_rec, idle_rec;

  assign nxt = (pos_q == POS_MAX) ? pos_q : pos_q + POSITION_BITS'(1);

  always_comb begin
    mode_d     = mode_q;
    begin_d    = begin_q;
    pos_d      = nxt;
    line_d     = line_q;
    inval_d    = inval_q;
    first_v    = 1'b0;
    first_k    = KIND_INVALID;
    first_s    = begin_q;
    first_e    = pos_q;
    idle_v     = 1'b0;
    idle_k     = KIND_INVALID;
    idle_s     = pos_q;
    idle_e     = nxt;
    idle_clean = 1'b0;
    rescan     = 1'b0;
    restart    = 1'b0;

    case (mode_q)
      MODE_HALT: begin
        restart = is_end(byte_i);
      end
      MODE_COMMENT: begin
        if (byte_i == CH_RBRACE) begin
          first_v = 1'b1;
          first_k = KIND_COMMENT;
          mode_d  = MODE_IDLE;
        end else if (is_end(byte_i)) begin
          first_v = 1'b1;
          first_k = KIND_ABORT;
          restart = 1'b1;
        end
      end
      MODE_STRING: begin
        if (byte_i == CH_QUOTE) begin
          first_v = 1'b1;
          first_k = KIND_STRING;
          mode_d  = MODE_IDLE;
        end else if (is_end(byte_i)) begin
          first_v = 1'b1;
          first_k = KIND_ABORT;
          restart = 1'b1;
        end else if ((byte_i == CH_CR) || (byte_i == CH_LF)) begin
          first_v = 1'b1;
          first_k = KIND_ABORT;
          mode_d  = MODE_HALT;
        end
      end
      MODE_IDENT: begin
        if (!(is_letter(byte_i) || is_digit(byte_i) || (byte_i == CH_UNDER))) begin
          first_v = 1'b1;
          first_k = KIND_IDENT;
          rescan  = 1'b1;
        end
      end
      MODE_NUM: begin
        if (byte_i == CH_DOT) begin
          mode_d = MODE_NUM_DOT;
        end else if (!is_digit(byte_i)) begin
          first_v = 1'b1;
          first_k = KIND_NUMBER;
          rescan  = 1'b1;
        end
      end
      MODE_NUM_DOT: begin
        if (is_digit(byte_i)) begin
          mode_d = MODE_NUM;
        end else begin
          first_v = 1'b1;
          first_k = KIND_INVALID;
          rescan  = 1'b1;
        end
      end
      MODE_LT, MODE_GT, MODE_COLON: begin
        first_v = 1'b1;
        if (byte_i == CH_EQUAL) begin
          first_e = nxt;
          first_k = (mode_q == MODE_LT) ? KIND_LE :
                    (mode_q == MODE_GT) ? KIND_GE : KIND_ASSIGN;
          mode_d  = MODE_IDLE;
        end else begin
          first_k = (mode_q == MODE_LT) ? KIND_LT :
                    (mode_q == MODE_GT) ? KIND_GT : KIND_INVALID;
          rescan  = 1'b1;
        end
      end
      default: begin
        rescan = 1'b1;
      end
    endcase

    if (first_v && (first_k == KIND_INVALID)) begin
      inval_d = 1'b1;
    end

    if (rescan) begin
      mode_d  = MODE_IDLE;
      begin_d = pos_q;
      if (is_end(byte_i)) begin
        idle_v     = 1'b1;
        idle_k     = KIND_END;
        idle_e     = pos_q;
        idle_clean = !inval_d;
        restart    = 1'b1;
      end else if (byte_i == CH_LBRACE) begin
        begin_d = nxt;
        mode_d  = MODE_COMMENT;
      end else if (byte_i == CH_QUOTE) begin
        begin_d = nxt;
        mode_d  = MODE_STRING;
      end else if (byte_i == CH_LT) begin
        mode_d = MODE_LT;
      end else if (byte_i == CH_GT) begin
        mode_d = MODE_GT;
      end else if (byte_i == CH_COLON) begin
        mode_d = MODE_COLON;
      end else if (is_digit(byte_i)) begin
        mode_d = MODE_NUM;
      end else if (is_letter(byte_i)) begin
        mode_d = MODE_IDENT;
      end else if ((byte_i == CH_TAB) || (byte_i == CH_CR) || (byte_i == CH_SPACE)) begin
        mode_d = MODE_IDLE;
      end else if (byte_i == CH_LF) begin
        if (line_q != LINE_MAX) begin
          line_d = line_q + LINE_ONE;
        end
      end else begin
        idle_v = 1'b1;
        idle_k = op_kind(byte_i);
        if (idle_k == KIND_INVALID) begin
          inval_d = 1'b1;
        end
      end
    end

    if (restart) begin
      mode_d  = MODE_IDLE;
      begin_d = '0;
      pos_d   = '0;
      line_d  = LINE_ONE;
      inval_d = 1'b0;
    end
  end

  always_comb begin
    first_rec.kind      = first_k;
    first_rec.start_off = OFFSET_W'(first_s);
    first_rec.end_off   = OFFSET_W'(first_e);
    first_rec.line      = LINE_W'(line_q);
    first_rec.clean     = 1'b0;
    first_rec.last      = !idle_v;

    idle_rec.kind      = idle_k;
    idle_rec.start_off = OFFSET_W'(idle_s);
    idle_rec.end_off   = OFFSET_W'(idle_e);
    idle_rec.line      = LINE_W'(line_q);
    idle_rec.clean     = idle_clean;
    idle_rec.last      = 1'b1;

    scan_o.count = fire_i ? ({1'b0, first_v} + {1'b0, idle_v}) : 2'd0;
    scan_o.rec0  = first_v ? first_rec : idle_rec;
    scan_o.rec1  = idle_rec;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      begin_q <= '0;
      pos_q   <= '0;
      line_q  <= LINE_ONE;
      inval_q <= 1'b0;
    end else if (fire_i) begin
      mode_q  <= mode_d;
      begin_q <= begin_d;
      pos_q   <= pos_d;
      line_q  <= line_d;
      inval_q <= inval_d;
    end
  end

endmodule

FILE: sv/stt_fifo.sv
module stt_fifo import stt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  scan_out_t push_i,
  output logic      room_o,
  output logic      valid_o,
  input  logic      stall_i,
  output tok_rec_t  head_o
);

  tok_rec_t               mem_q [RES_DEPTH];
  logic [RES_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [RES_CNT_W-1:0]   cnt_q;
  logic                   pop;

  assign valid_o = (cnt_q != '0);
  assign pop     = valid_o && !stall_i;
  assign room_o  = (cnt_q <= RES_CNT_W'(RES_DEPTH - 2));
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.rec0;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_ptr_q + RES_PTR_W'(1)] <= push_i.rec1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + RES_PTR_W'(push_i.count);
      rd_ptr_q <= rd_ptr_q + RES_PTR_W'(pop);
      cnt_q    <= cnt_q + RES_CNT_W'(push_i.count) - RES_CNT_W'(pop);
    end
  end

endmodule

FILE: sv/source_text_tokenizer.sv
// Channel   Direction  Handshake                  Payload
// text      in         text_valid_i/text_stall_o   text_byte_i
// token     out        token_valid_o/token_stall_i token_kind_o, start_offset_o, end_offset_o,
//                                                  line_number_o, text_clean_o, last_of_run_o
// A byte is registered on acceptance and scanned once the result queue has room.
// Its results go into the result queue, which gives one result per cycle while not stalled.
// One byte per cycle is taken while each byte gives at most one result and no token stall.
// A byte that gives two results queues both, and the token port gives them in turn.
// Reset puts the scanner between tokens at offset 0, line 1, with an empty result queue.
// A stall on the token port backs up the four-entry queue, and the text port stalls
// while a byte is held and fewer than two entries are free.
`include "assert_macros.svh"

module source_text_tokenizer import stt_pkg::*; #(
  parameter int POSITION_BITS = POSITION_BITS_DEF,
  parameter int LINE_BITS     = LINE_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                text_valid_i,
  output logic                text_stall_o,
  input  logic [TEXT_W-1:0]   text_byte_i,
  output logic                token_valid_o,
  input  logic                token_stall_i,
  output logic [KIND_W-1:0]   token_kind_o,
  output logic [OFFSET_W-1:0] start_offset_o,
  output logic [OFFSET_W-1:0] end_offset_o,
  output logic [LINE_W-1:0]   line_number_o,
  output logic                text_clean_o,
  output logic                last_of_run_o
);

  logic [TEXT_W-1:0] byte_q;
  logic              byte_valid_q, byte_valid_d;
  logic              room, fire, accept;
  scan_out_t         scan;
  tok_rec_t          head;

  assign fire         = byte_valid_q && room;
  assign text_stall_o = byte_valid_q && !room;
  assign accept       = text_valid_i && !text_stall_o;
  assign byte_valid_d = accept || (byte_valid_q && !fire);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= text_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_valid_q <= 1'b0;
    end else begin
      byte_valid_q <= byte_valid_d;
    end
  end

  stt_scan #(
    .POSITION_BITS(POSITION_BITS),
    .LINE_BITS    (LINE_BITS)
  ) u_scan (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .fire_i(fire),
    .byte_i(byte_q),
    .scan_o(scan)
  );

  stt_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (scan),
    .room_o (room),
    .valid_o(token_valid_o),
    .stall_i(token_stall_i),
    .head_o (head)
  );

  assign token_kind_o   = head.kind;
  assign start_offset_o = head.start_off;
  assign end_offset_o   = head.end_off;
  assign line_number_o  = head.line;
  assign text_clean_o   = head.clean;
  assign last_of_run_o  = head.last;

  `STT_ASSERT_IMPL(a_scan_needs_byte, scan.count != 2'd0, fire)
  `STT_ASSERT_ALWAYS(a_scan_count_range, scan.count != 2'd3)
  `STT_ASSERT_IMPL(a_end_is_last, token_valid_o && (token_kind_o == KIND_END), last_of_run_o)
  `STT_ASSERT_IMPL(a_clean_on_end, token_valid_o && text_clean_o, token_kind_o == KIND_END)

endmodule

FILE: tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import stt_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int RANDOM_ITEMS = 1300;
  localparam int DRAIN_CYCLES = 16;

  typedef enum logic [3:0] {
    SCAN_IDLE,
    SCAN_IDENT,
    SCAN_NUM,
    SCAN_NUM_DOT,
    SCAN_LT,
    SCAN_GT,
    SCAN_COLON,
    SCAN_COMMENT,
    SCAN_STRING,
    SCAN_HALT
  } scan_state_e;

  typedef struct {
    logic [TEXT_W-1:0] text;
    bit                typed;
    tok_rec_t          rec;
  } directed_row_t;

  logic                clk;
  logic                rst_n       = 1'b0;
  logic                text_valid  = 1'b0;
  logic [TEXT_W-1:0]   text_byte   = '0;
  logic                token_stall = 1'b0;
  logic                text_stall;
  logic                token_valid;
  logic [KIND_W-1:0]   token_kind;
  logic [OFFSET_W-1:0] start_offset;
  logic [OFFSET_W-1:0] end_offset;
  logic [LINE_W-1:0]   line_number;
  logic                text_clean;
  logic                last_of_run;

  scan_state_e         scan_mode = SCAN_IDLE;
  logic [OFFSET_W-1:0] tok_begin = '0;
  logic [OFFSET_W-1:0] byte_pos  = '0;
  logic [LINE_W-1:0]   line_cnt  = LINE_W'(1);
  logic                bad_seen  = 1'b0;

  tok_rec_t      expected_tokens[$];
  directed_row_t directed_rows[$];
  int            error_count  = 0;
  int            cycle_count  = 0;
  int            sent_items   = 0;
  int            scan_results = 0;
  bit            steady       = 1'b0;
  string         op_chars     = "();+-*/^=#&|%";

  source_text_tokenizer u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .text_valid_i   (text_valid),
    .text_stall_o   (text_stall),
    .text_byte_i    (text_byte),
    .token_valid_o  (token_valid),
    .token_stall_i  (token_stall),
    .token_kind_o   (token_kind),
    .start_offset_o (start_offset),
    .end_offset_o   (end_offset),
    .line_number_o  (line_number),
    .text_clean_o   (text_clean),
    .last_of_run_o  (last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic flag_error(input string msg);
    error_count++;
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  function automatic bit ends_text(input logic [TEXT_W-1:0] b);
    return (b == CH_NUL) || (b == CH_BS) || (b == CH_VT);
  endfunction

  function automatic bit digit_byte(input logic [TEXT_W-1:0] b);
    return (b >= "0") && (b <= "9");
  endfunction

  function automatic bit letter_byte(input logic [TEXT_W-1:0] b);
    return ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z"));
  endfunction

  function automatic token_kind_e operator_kind(input logic [TEXT_W-1:0] b);
    case (b)
      "(": return KIND_LPAREN;
      ")": return KIND_RPAREN;
      ";": return KIND_SEMI;
      "+": return KIND_PLUS;
      "-": return KIND_MINUS;
      "*": return KIND_STAR;
      "/": return KIND_SLASH;
      "^": return KIND_CARET;
      "=": return KIND_EQUAL;
      "#": return KIND_HASH;
      "&": return KIND_AMP;
      "|": return KIND_BAR;
      "%": return KIND_PERCENT;
      default: return KIND_INVALID;
    endcase
  endfunction

  function automatic void restart_text();
    scan_mode = SCAN_IDLE;
    tok_begin = '0;
    byte_pos  = '0;
    line_cnt  = LINE_W'(1);
    bad_seen  = 1'b0;
  endfunction

  function automatic void push_token(input token_kind_e kind, input logic [OFFSET_W-1:0] s,
                                     input logic [OFFSET_W-1:0] e, input logic clean);
    tok_rec_t r;
    r.kind      = kind;
    r.start_off = s;
    r.end_off   = e;
    r.line      = line_cnt;
    r.clean     = clean;
    r.last      = 1'b0;
    expected_tokens = {expected_tokens, r};
    if (kind == KIND_INVALID) begin
      bad_seen = 1'b1;
    end
  endfunction

  // Advances the scanner copy by one byte and queues the tokens it yields.
  // A token that ends on this byte comes out ahead of what the byte starts.
  function automatic int predict_byte(input logic [TEXT_W-1:0] b);
    logic [OFFSET_W-1:0] pos;
    logic [OFFSET_W-1:0] nxt;
    int                  depth;
    bit                  rescan;
    pos    = byte_pos;
    nxt    = (pos == {OFFSET_W{1'b1}}) ? pos : pos + 1'b1;
    depth  = expected_tokens.size();
    rescan = 1'b0;
    case (scan_mode)
      SCAN_HALT: begin
        if (ends_text(b)) begin
          restart_text();
        end else begin
          byte_pos = nxt;
        end
      end
      SCAN_COMMENT: begin
        if (b == CH_RBRACE) begin
          push_token(KIND_COMMENT, tok_begin, pos, 1'b0);
          scan_mode = SCAN_IDLE;
          byte_pos  = nxt;
        end else if (ends_text(b)) begin
          push_token(KIND_ABORT, tok_begin, pos, 1'b0);
          restart_text();
        end else begin
          byte_pos = nxt;
        end
      end
      SCAN_STRING: begin
        if (b == CH_QUOTE) begin
          push_token(KIND_STRING, tok_begin, pos, 1'b0);
          scan_mode = SCAN_IDLE;
          byte_pos  = nxt;
        end else if (ends_text(b)) begin
          push_token(KIND_ABORT, tok_begin, pos, 1'b0);
          restart_text();
        end else if (b == CH_CR || b == CH_LF) begin
          push_token(KIND_ABORT, tok_begin, pos, 1'b0);
          scan_mode = SCAN_HALT;
          byte_pos  = nxt;
        end else begin
          byte_pos = nxt;
        end
      end
      SCAN_IDENT: begin
        if (letter_byte(b) || digit_byte(b) || b == CH_UNDER) begin
          byte_pos = nxt;
        end else begin
          push_token(KIND_IDENT, tok_begin, pos, 1'b0);
          rescan = 1'b1;
        end
      end
      SCAN_NUM: begin
        if (digit_byte(b)) begin
          byte_pos = nxt;
        end else if (b == CH_DOT) begin
          scan_mode = SCAN_NUM_DOT;
          byte_pos  = nxt;
        end else begin
          push_token(KIND_NUMBER, tok_begin, pos, 1'b0);
          rescan = 1'b1;
        end
      end
      SCAN_NUM_DOT: begin
        if (digit_byte(b)) begin
          scan_mode = SCAN_NUM;
          byte_pos  = nxt;
        end else begin
          push_token(KIND_INVALID, tok_begin, pos, 1'b0);
          rescan = 1'b1;
        end
      end
      SCAN_LT, SCAN_GT, SCAN_COLON: begin
        if (b == CH_EQUAL) begin
          push_token((scan_mode == SCAN_LT) ? KIND_LE :
                     (scan_mode == SCAN_GT) ? KIND_GE : KIND_ASSIGN, tok_begin, nxt, 1'b0);
          scan_mode = SCAN_IDLE;
          byte_pos  = nxt;
        end else begin
          push_token((scan_mode == SCAN_LT) ? KIND_LT :
                     (scan_mode == SCAN_GT) ? KIND_GT : KIND_INVALID, tok_begin, pos, 1'b0);
          rescan = 1'b1;
        end
      end
      default: begin
        rescan = 1'b1;
      end
    endcase
    if (rescan) begin
      scan_mode = SCAN_IDLE;
      if (ends_text(b)) begin
        push_token(KIND_END, pos, pos, !bad_seen);
        restart_text();
      end else begin
        tok_begin = pos;
        if (b == CH_LBRACE) begin
          tok_begin = nxt;
          scan_mode = SCAN_COMMENT;
        end else if (b == CH_QUOTE) begin
          tok_begin = nxt;
          scan_mode = SCAN_STRING;
        end else if (b == CH_LT) begin
          scan_mode = SCAN_LT;
        end else if (b == CH_GT) begin
          scan_mode = SCAN_GT;
        end else if (b == CH_COLON) begin
          scan_mode = SCAN_COLON;
        end else if (digit_byte(b)) begin
          scan_mode = SCAN_NUM;
        end else if (letter_byte(b)) begin
          scan_mode = SCAN_IDENT;
        end else if (b == CH_TAB || b == CH_CR || b == CH_SPACE) begin
        end else if (b == CH_LF) begin
          if (line_cnt != {LINE_W{1'b1}}) begin
            line_cnt = line_cnt + 1'b1;
          end
        end else begin
          push_token(operator_kind(b), pos, nxt, 1'b0);
        end
        byte_pos = nxt;
      end
    end
    if (expected_tokens.size() > depth) begin
      expected_tokens[expected_tokens.size() - 1].last = 1'b1;
    end
    return expected_tokens.size() - depth;
  endfunction

  task automatic send_text_byte(input logic [TEXT_W-1:0] b);
    while (!steady && $urandom_range(99) < 31) begin
      text_valid <= 1'b0;
      @(posedge clk);
    end
    text_valid <= 1'b1;
    text_byte  <= b;
    do begin
      @(posedge clk);
    end while (text_stall);
    scan_results = predict_byte(b);
    sent_items++;
  endtask

  function automatic directed_row_t plain_row(input logic [TEXT_W-1:0] b);
    directed_row_t row;
    row.text  = b;
    row.typed = 1'b0;
    row.rec   = '0;
    return row;
  endfunction

  function automatic directed_row_t typed_row(input logic [TEXT_W-1:0] b, input token_kind_e k,
                                              input int s, input int e, input int ln,
                                              input logic clean);
    directed_row_t row;
    row.text          = b;
    row.typed         = 1'b1;
    row.rec.kind      = k;
    row.rec.start_off = s[OFFSET_W-1:0];
    row.rec.end_off   = e[OFFSET_W-1:0];
    row.rec.line      = ln[LINE_W-1:0];
    row.rec.clean     = clean;
    row.rec.last      = 1'b1;
    return row;
  endfunction

  function automatic logic [TEXT_W-1:0] ident_char();
    int pick;
    pick = $urandom_range(62);
    if (pick < 26) return TEXT_W'("a" + pick);
    if (pick < 52) return TEXT_W'("A" + pick - 26);
    if (pick < 62) return TEXT_W'("0" + pick - 52);
    return CH_UNDER;
  endfunction

  function automatic logic [TEXT_W-1:0] body_char(input bit in_string);
    logic [TEXT_W-1:0] b;
    do begin
      b = TEXT_W'($urandom_range(255));
    end while (ends_text(b) || (!in_string && b == CH_RBRACE) ||
               (in_string && (b == CH_QUOTE || b == CH_CR || b == CH_LF)));
    return b;
  endfunction

  function automatic logic [TEXT_W-1:0] blank_char();
    case ($urandom_range(3))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_CR;
      default: return CH_LF;
    endcase
  endfunction

  function automatic logic [TEXT_W-1:0] end_char();
    case ($urandom_range(2))
      0: return CH_NUL;
      1: return CH_BS;
      default: return CH_VT;
    endcase
  endfunction

  task automatic send_lexeme();
    int pick;
    int len;
    logic [TEXT_W-1:0] b;
    pick = $urandom_range(99);
    if (pick < 16) begin
      send_text_byte(letter_byte(ident_char()) ? ident_char() : "q");
      len = $urandom_range(5);
      repeat (len) send_text_byte(ident_char());
    end else if (pick < 30) begin
      len = $urandom_range(1, 4);
      repeat (len) send_text_byte(TEXT_W'("0" + $urandom_range(9)));
      case ($urandom_range(2))
        1: begin
          send_text_byte(CH_DOT);
          len = $urandom_range(1, 3);
          repeat (len) send_text_byte(TEXT_W'("0" + $urandom_range(9)));
        end
        2: send_text_byte(CH_DOT);
        default: begin
        end
      endcase
    end else if (pick < 44) begin
      send_text_byte(op_chars[$urandom_range(12)]);
    end else if (pick < 54) begin
      case ($urandom_range(5))
        0: begin
          send_text_byte(CH_LT);
          send_text_byte(CH_EQUAL);
        end
        1: begin
          send_text_byte(CH_GT);
          send_text_byte(CH_EQUAL);
        end
        2: begin
          send_text_byte(CH_COLON);
          send_text_byte(CH_EQUAL);
        end
        3: send_text_byte(CH_LT);
        4: send_text_byte(CH_GT);
        default: send_text_byte(CH_COLON);
      endcase
    end else if (pick < 63) begin
      send_text_byte(CH_QUOTE);
      len = $urandom_range(5);
      repeat (len) send_text_byte(body_char(1'b1));
      send_text_byte(CH_QUOTE);
    end else if (pick < 71) begin
      send_text_byte(CH_LBRACE);
      len = $urandom_range(6);
      repeat (len) send_text_byte(body_char(1'b0));
      send_text_byte(CH_RBRACE);
    end else if (pick < 79) begin
      len = $urandom_range(1, 3);
      repeat (len) send_text_byte(blank_char());
    end else if (pick < 85) begin
      b = TEXT_W'($urandom_range(255));
      send_text_byte(b);
    end else if (pick < 90) begin
      send_text_byte(CH_LBRACE);
      len = $urandom_range(4);
      repeat (len) send_text_byte(body_char(1'b0));
      send_text_byte(end_char());
    end else if (pick < 95) begin
      send_text_byte(CH_QUOTE);
      len = $urandom_range(4);
      repeat (len) send_text_byte(body_char(1'b1));
      send_text_byte(end_char());
    end else begin
      send_text_byte(CH_QUOTE);
      len = $urandom_range(3);
      repeat (len) send_text_byte(body_char(1'b1));
      send_text_byte($urandom_range(1) ? CH_CR : CH_LF);
      len = $urandom_range(4);
      repeat (len) send_text_byte(body_char(1'b1));
    end
  endtask

  always @(posedge clk) begin
    token_stall <= !steady && ($urandom_range(99) < 31);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk) begin : check_tokens
    tok_rec_t want;
    if (rst_n && token_valid && !token_stall) begin
      if (expected_tokens.size() == 0) begin
        flag_error($sformatf("token kind %0d with nothing expected", token_kind));
      end else begin
        want = expected_tokens.pop_front();
        if (token_kind != want.kind) begin
          flag_error($sformatf("kind %0d, want %0d", token_kind, want.kind));
        end
        if (start_offset != want.start_off) begin
          flag_error($sformatf("start %0d, want %0d", start_offset, want.start_off));
        end
        if (end_offset != want.end_off) begin
          flag_error($sformatf("end %0d, want %0d", end_offset, want.end_off));
        end
        if (line_number != want.line) begin
          flag_error($sformatf("line %0d, want %0d", line_number, want.line));
        end
        if (text_clean != want.clean) begin
          flag_error($sformatf("clean %0b, want %0b", text_clean, want.clean));
        end
        if (last_of_run != want.last) begin
          flag_error($sformatf("last %0b, want %0b", last_of_run, want.last));
        end
      end
    end
  end

  initial begin : stimulus
    int random_items;
    int sent_mark;
    int count;
    directed_rows = {directed_rows, plain_row("a")};
    directed_rows = {directed_rows, plain_row("9")};
    directed_rows = {directed_rows, typed_row("<", KIND_IDENT, 0, 2, 1, 1'b0)};
    directed_rows = {directed_rows, typed_row(CH_EQUAL, KIND_LE, 2, 4, 1, 1'b0)};
    directed_rows = {directed_rows, plain_row(CH_COLON)};
    directed_rows = {directed_rows, typed_row("x", KIND_INVALID, 4, 5, 1, 1'b0)};
    directed_rows = {directed_rows, plain_row(CH_LF)};
    directed_rows = {directed_rows, plain_row("7")};
    directed_rows = {directed_rows, plain_row(CH_DOT)};
    directed_rows = {directed_rows, typed_row(";", KIND_SEMI, 9, 10, 2, 1'b0)};
    directed_rows = {directed_rows, plain_row(CH_LBRACE)};
    directed_rows = {directed_rows, plain_row(8'hFF)};
    directed_rows = {directed_rows, plain_row(CH_RBRACE)};
    directed_rows = {directed_rows, plain_row(CH_QUOTE)};
    directed_rows = {directed_rows, plain_row(8'h80)};
    directed_rows = {directed_rows, typed_row(CH_CR, KIND_ABORT, 14, 15, 2, 1'b0)};
    directed_rows = {directed_rows, plain_row("z")};
    directed_rows = {directed_rows, plain_row(CH_BS)};
    directed_rows = {directed_rows, plain_row(CH_GT)};
    directed_rows = {directed_rows, typed_row("%", KIND_PERCENT, 1, 2, 1, 1'b0)};
    directed_rows = {directed_rows, plain_row("3")};
    directed_rows = {directed_rows, typed_row(CH_NUL, KIND_END, 3, 3, 1, 1'b1)};
    directed_rows = {directed_rows, plain_row(CH_LBRACE)};
    directed_rows = {directed_rows, typed_row(CH_VT, KIND_ABORT, 1, 1, 1, 1'b0)};
    directed_rows = {directed_rows, typed_row("@", KIND_INVALID, 0, 1, 1, 1'b0)};
    directed_rows = {directed_rows, typed_row(CH_NUL, KIND_END, 1, 1, 1, 1'b0)};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_text_byte(directed_rows[i].text);
      if (directed_rows[i].typed &&
          (scan_results == 0 || expected_tokens[$] != directed_rows[i].rec)) begin
        flag_error($sformatf("directed byte %0d: predicted token differs from table", i));
      end
    end

    // Texts of well-formed lexemes, mixed with stray bytes and broken tokens.
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      count = $urandom_range(1, 12);
      repeat (count) begin
        steady = (random_items >= 450) && (random_items < 750);
        sent_mark = sent_items;
        send_lexeme();
        if ($urandom_range(99) < 55) begin
          send_text_byte(blank_char());
        end
        random_items += sent_items - sent_mark;
      end
      send_text_byte(end_char());
      random_items++;
    end
    steady = 1'b0;

    text_valid <= 1'b0;
    while (expected_tokens.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
